@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every clock edge while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every clock edge, during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/ial_pkg.sv @@
// ----------------------------------------------------------------------------
// ial_pkg
// Types, codes and sizes shared by the indexed insert/remove list.
// ----------------------------------------------------------------------------
package ial_pkg;

  localparam int Capacity = 16;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int ActW     = 3;
  localparam int IdxW     = 5;
  localparam int DataW    = 32;
  localparam int CountW   = 5;
  localparam int StatW    = 2;
  localparam int CmpW     = (CntW > IdxW) ? CntW : IdxW;

  localparam logic [ActW-1:0] ActPush   = 3'd0;
  localparam logic [ActW-1:0] ActPop    = 3'd1;
  localparam logic [ActW-1:0] ActGet    = 3'd2;
  localparam logic [ActW-1:0] ActInsert = 3'd3;
  localparam logic [ActW-1:0] ActRemove = 3'd4;

  localparam logic [StatW-1:0] StOk     = 2'd0;
  localparam logic [StatW-1:0] StBounds = 2'd1;
  localparam logic [StatW-1:0] StFull   = 2'd2;

  // Operations that passed their checks, for the beat being accepted.
  typedef struct packed {
    logic push;
    logic ins;
    logic rem;
    logic get;
  } ial_op_t;

  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [StatW-1:0] status;
  } ial_res_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } ial_cell_ctrl_t;

endpackage

@@ src/ial_cell.sv @@
// ----------------------------------------------------------------------------
// ial_cell
// One list slot: holds a word, loads a new one or takes a neighbor's word.
// ----------------------------------------------------------------------------
module ial_cell (
  input  logic                          clk_i,
  input  ial_pkg::ial_cell_ctrl_t       ctrl_i,
  input  logic signed [ial_pkg::DataW-1:0] value_i,
  input  logic signed [ial_pkg::DataW-1:0] left_i,
  input  logic signed [ial_pkg::DataW-1:0] right_i,
  output logic signed [ial_pkg::DataW-1:0] word_o
);

  logic signed [ial_pkg::DataW-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load) begin
      word_d = value_i;
    end else if (ctrl_i.shift_up) begin
      word_d = left_i;
    end else if (ctrl_i.shift_down) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

@@ src/ial_ctrl.sv @@
// ----------------------------------------------------------------------------
// ial_ctrl
// Holds the entry count, checks bounds and capacity, decodes the action.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ial_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ial_pkg::ActW-1:0]      action_i,
  input  logic [ial_pkg::IdxW-1:0]      index_i,
  output ial_pkg::ial_op_t              op_o,
  output logic [ial_pkg::CntW-1:0]      count_o,
  output ial_pkg::ial_res_t             res_o
);

  logic [ial_pkg::CntW-1:0]  count_d, count_q;
  logic [ial_pkg::CmpW-1:0]  idx_x, cnt_x;
  logic [ial_pkg::StatW-1:0] status;
  ial_pkg::ial_op_t          op;
  logic                      full;

  assign idx_x = ial_pkg::CmpW'(index_i);
  assign cnt_x = ial_pkg::CmpW'(count_q);
  assign full  = (count_q == ial_pkg::CntW'(ial_pkg::Capacity));

  always_comb begin
    op      = '0;
    status  = ial_pkg::StOk;
    count_d = count_q;
    case (action_i)
      ial_pkg::ActPush: begin
        if (full) begin
          status = ial_pkg::StFull;
        end else begin
          op.push = 1'b1;
          count_d = count_q + ial_pkg::CntW'(1);
        end
      end
      ial_pkg::ActPop: begin
        if (count_q != '0) begin
          count_d = count_q - ial_pkg::CntW'(1);
        end
      end
      ial_pkg::ActGet: begin
        if (idx_x >= cnt_x) begin
          status = ial_pkg::StBounds;
        end else begin
          op.get = 1'b1;
        end
      end
      ial_pkg::ActInsert: begin
        // The bounds check wins over the full check.
        if (idx_x > cnt_x) begin
          status = ial_pkg::StBounds;
        end else if (full) begin
          status = ial_pkg::StFull;
        end else begin
          op.ins  = 1'b1;
          count_d = count_q + ial_pkg::CntW'(1);
        end
      end
      ial_pkg::ActRemove: begin
        if (idx_x >= cnt_x) begin
          status = ial_pkg::StBounds;
        end else begin
          op.rem  = 1'b1;
          count_d = count_q - ial_pkg::CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign op_o         = accept_i ? op : '0;
  assign count_o      = count_q;
  assign res_o.count  = count_d;
  assign res_o.status = status;

  `ASSERT_CLK(a_count_cap,
    count_q <= ial_pkg::CntW'(ial_pkg::Capacity),
    "count over capacity")
  `ASSERT_CLK(a_grow,
    (op_o.push || op_o.ins) |=> count_q == $past(count_q) + ial_pkg::CntW'(1),
    "count did not grow")
  `ASSERT_CLK(a_refused,
    (accept_i && status != ial_pkg::StOk) |=> $stable(count_q),
    "refused beat changed count")
  `ASSERT_CLK(a_full_flag, (status == ial_pkg::StFull) |-> full, "full reported below capacity")

endmodule

@@ src/indexed_insert_remove_list.sv @@
// A result beat appears in the cycle after its item is accepted.
// One item per cycle while the output is not stalled; every cell of the chain
// shifts, loads or holds in the accepting cycle, so no item waits on another.
// An item is taken while the result register is empty or being drained.
// Reset clears the entry count and the result valid; cell words start unknown.
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Ordered list of signed words held in a chain of cells, with push, pop,
// get, insert at an index and remove at an index.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ial_pkg::ActW-1:0]         action_i,
  input  logic [ial_pkg::IdxW-1:0]         index_i,
  input  logic signed [ial_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ial_pkg::DataW-1:0] read_value_o,
  output logic [ial_pkg::CountW-1:0]       count_o,
  output logic [ial_pkg::StatW-1:0]        status_o
);

  logic                             accept;
  ial_pkg::ial_op_t                 op;
  ial_pkg::ial_res_t                res;
  logic [ial_pkg::CntW-1:0]         count_q;
  logic [ial_pkg::CmpW-1:0]         idx_x, cnt_x;
  logic signed [ial_pkg::DataW-1:0] words [ial_pkg::Capacity];
  logic [ial_pkg::DataW-1:0]        hit_word [ial_pkg::Capacity];
  logic [ial_pkg::DataW-1:0]        rd;

  logic                             out_valid_q;
  logic signed [ial_pkg::DataW-1:0] read_value_q;
  logic [ial_pkg::CountW-1:0]       count_out_q;
  logic [ial_pkg::StatW-1:0]        status_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  ial_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .action_i (action_i),
    .index_i  (index_i),
    .op_o     (op),
    .count_o  (count_q),
    .res_o    (res)
  );

  assign idx_x = ial_pkg::CmpW'(index_i);
  assign cnt_x = ial_pkg::CmpW'(count_q);

  for (genvar i = 0; i < ial_pkg::Capacity; i++) begin : g_cell
    logic [ial_pkg::CmpW-1:0]         pos;
    ial_pkg::ial_cell_ctrl_t          ctrl;
    logic signed [ial_pkg::DataW-1:0] left, right;

    assign pos = ial_pkg::CmpW'(i);

    always_comb begin
      ctrl.load       = (op.push && pos == cnt_x) || (op.ins && pos == idx_x);
      ctrl.shift_up   = op.ins && pos > idx_x;
      ctrl.shift_down = op.rem && pos >= idx_x;
    end

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = words[i-1];
    end
    if (i == ial_pkg::Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = words[i+1];
    end

    ial_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .word_o  (words[i])
    );

    // Each cell gates its own word onto the read bus when addressed.
    assign hit_word[i] = (op.get && pos == idx_x) ? words[i] : '0;
  end

  always_comb begin
    rd = '0;
    for (int i = 0; i < ial_pkg::Capacity; i++) begin
      rd = rd | hit_word[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= rd;
      count_out_q  <= ial_pkg::CountW'(ial_pkg::CmpW'(res.count));
      status_q     <= res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign count_o      = count_out_q;
  assign status_o     = status_q;

endmodule
